// ===== hw/rtl/kmf_pkg.sv =====
`default_nettype none

package kmf_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int VERTEX_W         = 8;
    localparam int WEIGHT_W         = 32;
    localparam int VCOUNT_W         = 9;
    localparam int RANK_W           = 4;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(256);
    localparam logic [RANK_W-1:0]   RANK_MAX     = RANK_W'(15);

    typedef struct packed {
        logic [VERTEX_W-1:0]        vtx_a;
        logic [VERTEX_W-1:0]        vtx_b;
        logic [VERTEX_W-1:0]        vtx_lo;
        logic [VERTEX_W-1:0]        vtx_hi;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       last;
        logic                       bad;
    } edge_item_t;

    typedef struct packed {
        logic                       accepted;
        logic [VERTEX_W-1:0]        vtx_lo;
        logic [VERTEX_W-1:0]        vtx_hi;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       done;
        logic                       bad;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FA_WALK,
        ST_FA_COMP,
        ST_FB_WALK,
        ST_FB_COMP,
        ST_UNION,
        ST_RANK,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kmf_queue.sv =====
`default_nettype none

module kmf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kmf_front.sv =====
`default_nettype none

module kmf_front #(
    parameter int MAX_VERTICES = kmf_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic [kmf_pkg::VERTEX_W-1:0]           edge_from,
    input  wire logic [kmf_pkg::VERTEX_W-1:0]           edge_to,
    input  wire logic signed [kmf_pkg::WEIGHT_W-1:0]    edge_weight,
    input  wire logic                                   last_edge,
    input  wire logic [$clog2(MAX_VERTICES+1)-1:0]      n_eff,
    output logic                                        q_push,
    output kmf_pkg::edge_item_t                         q_data,
    input  wire logic                                   q_full
);

    import kmf_pkg::*;

    logic from_bad;
    logic to_bad;
    logic from_le_to;

    assign from_bad   = (32'(edge_from) >= 32'(n_eff));
    assign to_bad     = (32'(edge_to) >= 32'(n_eff));
    assign from_le_to = (edge_from <= edge_to);

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        q_data.vtx_a  = edge_from;
        q_data.vtx_b  = edge_to;
        q_data.vtx_lo = from_le_to ? edge_from : edge_to;
        q_data.vtx_hi = from_le_to ? edge_to : edge_from;
        q_data.weight = edge_weight;
        q_data.last   = last_edge;
        q_data.bad    = from_bad || to_bad;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kmf_back.sv =====
`default_nettype none

module kmf_back #(
    parameter int MAX_VERTICES = kmf_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [$clog2(MAX_VERTICES+1)-1:0]   target,
    input  wire kmf_pkg::edge_item_t                 in_data,
    input  wire logic                                in_empty,
    output logic                                     in_pop,
    output kmf_pkg::result_t                         out_data,
    input  wire logic                                out_full,
    output logic                                     out_push
);

    import kmf_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES+1);
    localparam int MW = RANK_W + VW;

    state_t state_reg;
    state_t state_next;

    edge_item_t        item_reg;
    logic [NW-1:0]     count_reg;
    logic              acc_reg;
    logic [VW-1:0]     root_a_reg;
    logic [VW-1:0]     root_b_reg;
    logic [RANK_W-1:0] rank_a_reg;
    logic [RANK_W-1:0] rank_b_reg;

    // {rank, parent} per vertex; an entry with a clear valid bit is its own root
    logic [MW-1:0]           node_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] valid_reg;
    logic [MW-1:0]           rd_word_reg;
    logic [VW-1:0]           rd_addr_reg;
    logic                    rd_valid_reg;

    logic              rd_en;
    logic [VW-1:0]     rd_addr;
    logic              mem_we;
    logic [VW-1:0]     wr_addr;
    logic [MW-1:0]     wr_word;

    logic [VW-1:0]     a_idx;
    logic [VW-1:0]     b_idx;
    logic [VW-1:0]     node;
    logic [VW-1:0]     node_par;
    logic [RANK_W-1:0] node_rank;
    logic              skip;
    logic [RANK_W-1:0] rank_b_inc;

    assign a_idx      = VW'(item_reg.vtx_a);
    assign b_idx      = VW'(item_reg.vtx_b);
    assign node       = rd_addr_reg;
    assign node_par   = rd_valid_reg ? rd_word_reg[VW-1:0] : rd_addr_reg;
    assign node_rank  = rd_valid_reg ? rd_word_reg[MW-1:VW] : '0;
    assign skip       = in_data.bad || (count_reg >= target);
    assign rank_b_inc = (rank_b_reg == RANK_MAX) ? RANK_MAX : rank_b_reg + RANK_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!in_empty)
                begin
                    state_next = skip ? ST_RESULT : ST_FA_WALK;
                end
            end
            ST_FA_WALK:
            begin
                if (node_par == node)
                begin
                    state_next = ST_FA_COMP;
                end
            end
            ST_FA_COMP:
            begin
                if (node == root_a_reg)
                begin
                    state_next = ST_FB_WALK;
                end
            end
            ST_FB_WALK:
            begin
                if (node_par == node)
                begin
                    state_next = ST_FB_COMP;
                end
            end
            ST_FB_COMP:
            begin
                if (node == root_b_reg)
                begin
                    state_next = ST_UNION;
                end
            end
            ST_UNION:
            begin
                if (root_a_reg != root_b_reg && rank_a_reg == rank_b_reg)
                begin
                    state_next = ST_RANK;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RANK:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_pop   = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        mem_we   = 1'b0;
        wr_addr  = '0;
        wr_word  = '0;
        out_push = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!in_empty)
                begin
                    in_pop  = 1'b1;
                    rd_en   = !skip;
                    rd_addr = VW'(in_data.vtx_a);
                end
            end
            ST_FA_WALK, ST_FB_WALK:
            begin
                rd_en = 1'b1;
                if (node_par == node)
                begin
                    // restart from the endpoint to compress the path
                    rd_addr = (state_reg == ST_FA_WALK) ? a_idx : b_idx;
                end
                else
                begin
                    rd_addr = node_par;
                end
            end
            ST_FA_COMP:
            begin
                rd_en = 1'b1;
                if (node == root_a_reg)
                begin
                    rd_addr = b_idx;
                end
                else
                begin
                    rd_addr = node_par;
                    mem_we  = 1'b1;
                    wr_addr = node;
                    wr_word = {node_rank, root_a_reg};
                end
            end
            ST_FB_COMP:
            begin
                if (node != root_b_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = node_par;
                    mem_we  = 1'b1;
                    wr_addr = node;
                    wr_word = {node_rank, root_b_reg};
                end
            end
            ST_UNION:
            begin
                if (root_a_reg != root_b_reg)
                begin
                    mem_we = 1'b1;
                    if (rank_a_reg > rank_b_reg)
                    begin
                        wr_addr = root_b_reg;
                        wr_word = {rank_b_reg, root_a_reg};
                    end
                    else
                    begin
                        wr_addr = root_a_reg;
                        wr_word = {rank_a_reg, root_b_reg};
                    end
                end
            end
            ST_RANK:
            begin
                mem_we  = 1'b1;
                wr_addr = root_b_reg;
                wr_word = {rank_b_inc, root_b_reg};
            end
            ST_RESULT:
            begin
                out_push = !out_full;
            end
            default:
            begin
                in_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_data.accepted = acc_reg;
        out_data.vtx_lo   = item_reg.vtx_lo;
        out_data.vtx_hi   = item_reg.vtx_hi;
        out_data.weight   = item_reg.weight;
        out_data.done     = (count_reg >= target);
        out_data.bad      = item_reg.bad;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[wr_addr] <= wr_word;
        end
        if (rd_en)
        begin
            rd_word_reg <= node_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            item_reg <= in_data;
        end
        if ((state_reg == ST_FA_WALK) && (node_par == node))
        begin
            root_a_reg <= node;
            rank_a_reg <= node_rank;
        end
        if ((state_reg == ST_FB_WALK) && (node_par == node))
        begin
            root_b_reg <= node;
            rank_b_reg <= node_rank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            count_reg    <= '0;
            acc_reg      <= 1'b0;
            rd_addr_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rd_en)
            begin
                rd_addr_reg  <= rd_addr;
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (in_pop)
            begin
                acc_reg <= 1'b0;
            end
            if ((state_reg == ST_UNION) && (root_a_reg != root_b_reg))
            begin
                acc_reg   <= 1'b1;
                count_reg <= count_reg + NW'(1);
            end
            if (mem_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            // drop the forest once the closing edge of a graph is out
            if (out_push && item_reg.last)
            begin
                valid_reg <= '0;
                count_reg <= '0;
            end
        end
    end

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && rd_en) |-> (wr_addr != rd_addr))
        else $error("memory read and write hit the same vertex");

    a_accept_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && acc_reg) |-> !item_reg.bad)
        else $error("edge with bad endpoint accepted");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && item_reg.last) |=> (count_reg == '0))
        else $error("accepted count not cleared after last edge");

    a_same_root_no_merge: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UNION) && (root_a_reg == root_b_reg)) |-> !mem_we)
        else $error("merge issued for edge inside one tree");

endmodule

`default_nettype wire

// ===== hw/rtl/kruskal_mst_edge_filter_top.sv =====
// Kruskal spanning-tree edge filter.
// Input channel: push/full with edge_from, edge_to, edge_weight, last_edge; a beat
// moves when push is high and full is low. Edges of one graph arrive in ascending
// weight order; last_edge closes the graph.
// Result channel: empty/pop; the oldest result sits on the result ports while empty
// is low and moves when pop is high. One result per edge, in input order.
// Config channel: cfg_valid/cfg_ready/cfg_data writes vertex_count; always ready.
// Write it only while no edge is in flight.
// Timing: a two-entry queue sits before and after the union-find engine. A rejected
// edge (bad endpoint or finished tree) goes from idle straight to the result state.
// Otherwise the engine finds the root of each endpoint in turn, then merges the two
// roots if they differ, with an extra rank update when equal ranks merge; each find
// walk reads the parent/rank memory (one read and one write port) once per hop, then
// walks again to compress the path. Parent-chain depths never exceed log2 of the
// vertex count. The result state pushes the result into the result queue unless that
// queue is full.
// Reset: the forest reads as all singletons at once (per-vertex valid bits), the
// accepted count is zero, vertex_count is 256 and both queues are empty.
// A stalled receiver fills the result queue, then the engine holds, then full rises.
`default_nettype none

module kruskal_mst_edge_filter_top #(
    parameter int MAX_VERTICES = kmf_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [kmf_pkg::VERTEX_W-1:0]        edge_from,
    input  wire logic [kmf_pkg::VERTEX_W-1:0]        edge_to,
    input  wire logic signed [kmf_pkg::WEIGHT_W-1:0] edge_weight,
    input  wire logic                                last_edge,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic                                     accepted,
    output logic [kmf_pkg::VERTEX_W-1:0]             vertex_low,
    output logic [kmf_pkg::VERTEX_W-1:0]             vertex_high,
    output logic signed [kmf_pkg::WEIGHT_W-1:0]      weight_out,
    output logic                                     tree_complete,
    output logic                                     bad_vertex,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [kmf_pkg::VCOUNT_W-1:0]        cfg_data
);

    import kmf_pkg::*;

    localparam int NW = $clog2(MAX_VERTICES+1);

    logic [VCOUNT_W-1:0] vertex_count_reg;
    logic [NW-1:0]       n_eff;
    logic [NW-1:0]       target;
    logic                vc_over;

    edge_item_t fq_wr_data;
    edge_item_t fq_rd_data;
    logic       fq_push;
    logic       fq_full;
    logic       fq_pop;
    logic       fq_empty;

    result_t    rq_wr_data;
    result_t    rq_rd_data;
    logic       rq_push;
    logic       rq_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VCOUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vertex_count_reg <= cfg_data;
        end
    end

    assign vc_over = (32'(vertex_count_reg) > 32'(MAX_VERTICES));
    assign n_eff   = vc_over ? NW'(MAX_VERTICES) : NW'(vertex_count_reg);
    assign target  = (n_eff == '0) ? '0 : n_eff - NW'(1);

    kmf_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .push        (push),
        .full        (full),
        .edge_from   (edge_from),
        .edge_to     (edge_to),
        .edge_weight (edge_weight),
        .last_edge   (last_edge),
        .n_eff       (n_eff),
        .q_push      (fq_push),
        .q_data      (fq_wr_data),
        .q_full      (fq_full)
    );

    kmf_queue #(
        .WIDTH ($bits(edge_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_edge_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .wr_data (fq_wr_data),
        .full    (fq_full),
        .pop     (fq_pop),
        .rd_data (fq_rd_data),
        .empty   (fq_empty)
    );

    kmf_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .target   (target),
        .in_data  (fq_rd_data),
        .in_empty (fq_empty),
        .in_pop   (fq_pop),
        .out_data (rq_wr_data),
        .out_full (rq_full),
        .out_push (rq_push)
    );

    kmf_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rq_push),
        .wr_data (rq_wr_data),
        .full    (rq_full),
        .pop     (pop),
        .rd_data (rq_rd_data),
        .empty   (empty)
    );

    assign accepted      = rq_rd_data.accepted;
    assign vertex_low    = rq_rd_data.vtx_lo;
    assign vertex_high   = rq_rd_data.vtx_hi;
    assign weight_out    = rq_rd_data.weight;
    assign tree_complete = rq_rd_data.done;
    assign bad_vertex    = rq_rd_data.bad;

endmodule

`default_nettype wire

// ===== sim/kruskal_mst_edge_filter_top_test.sv =====
`timescale 1ns / 100ps

module kruskal_mst_edge_filter_top_test;
    import kmf_pkg::*;

    localparam int NV           = MAX_VERTICES_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef enum bit {ROW_EDGE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [VERTEX_W-1:0]        src;
        logic [VERTEX_W-1:0]        dst;
        logic signed [WEIGHT_W-1:0] wt;
        logic                       fin;
        logic [VCOUNT_W-1:0]        vcount;
        bit                         typed;
        result_t                    want;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        push;
    logic                        full;
    logic [VERTEX_W-1:0]         edge_from;
    logic [VERTEX_W-1:0]         edge_to;
    logic signed [WEIGHT_W-1:0]  edge_weight;
    logic                        last_edge;
    logic                        empty;
    logic                        pop = 1'b0;
    logic                        accepted;
    logic [VERTEX_W-1:0]         vertex_low;
    logic [VERTEX_W-1:0]         vertex_high;
    logic signed [WEIGHT_W-1:0]  weight_out;
    logic                        tree_complete;
    logic                        bad_vertex;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [VCOUNT_W-1:0]         cfg_data;

    // predicted union-find forest and register copy
    logic [VERTEX_W-1:0]         forest_parent [NV];
    logic [RANK_W-1:0]           forest_rank [NV];
    logic [VCOUNT_W-1:0]         tree_edge_count;
    logic [VCOUNT_W-1:0]         vertex_count_reg;

    result_t                     pending_results [$];
    int                          mismatch_count = 0;
    int                          cycle_count = 0;
    int                          send_idle_pct = 0;
    int                          recv_idle_pct = 0;
    stim_row_t                   dir_tab [25];

    kruskal_mst_edge_filter_top #(
        .MAX_VERTICES (NV)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .edge_from     (edge_from),
        .edge_to       (edge_to),
        .edge_weight   (edge_weight),
        .last_edge     (last_edge),
        .empty         (empty),
        .pop           (pop),
        .accepted      (accepted),
        .vertex_low    (vertex_low),
        .vertex_high   (vertex_high),
        .weight_out    (weight_out),
        .tree_complete (tree_complete),
        .bad_vertex    (bad_vertex),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void forest_clear();
        for (int i = 0; i < NV; i++)
        begin
            forest_parent[i] = VERTEX_W'(i);
            forest_rank[i]   = '0;
        end
        tree_edge_count = '0;
    endfunction

    function automatic logic [VERTEX_W-1:0] forest_root(logic [VERTEX_W-1:0] v);
        logic [VERTEX_W-1:0] root;
        logic [VERTEX_W-1:0] nxt;
        root = v;
        while (forest_parent[root] != root)
            root = forest_parent[root];
        // hang every node on the path straight below the root
        while (v != root)
        begin
            nxt              = forest_parent[v];
            forest_parent[v] = root;
            v                = nxt;
        end
        return root;
    endfunction

    function automatic result_t mst_filter_predict(logic [VERTEX_W-1:0] a,
                                                   logic [VERTEX_W-1:0] b,
                                                   logic signed [WEIGHT_W-1:0] wt,
                                                   logic fin);
        result_t             r;
        logic [VCOUNT_W-1:0] n;
        logic [VCOUNT_W-1:0] target;
        logic [VERTEX_W-1:0] ra;
        logic [VERTEX_W-1:0] rb;
        n        = (vertex_count_reg > VCOUNT_W'(NV)) ? VCOUNT_W'(NV) : vertex_count_reg;
        target   = (n == 0) ? '0 : n - 1'b1;
        r.bad    = (VCOUNT_W'(a) >= n) || (VCOUNT_W'(b) >= n);
        r.accepted = 1'b0;
        if (!r.bad && tree_edge_count < target)
        begin
            ra = forest_root(a);
            rb = forest_root(b);
            if (ra != rb)
            begin
                if (forest_rank[ra] < forest_rank[rb])
                    forest_parent[ra] = rb;
                else if (forest_rank[ra] > forest_rank[rb])
                    forest_parent[rb] = ra;
                else
                begin
                    // equal ranks: first root goes below the second
                    forest_parent[ra] = rb;
                    if (forest_rank[rb] != RANK_MAX)
                        forest_rank[rb] = forest_rank[rb] + 1'b1;
                end
                tree_edge_count = tree_edge_count + 1'b1;
                r.accepted = 1'b1;
            end
        end
        r.done   = tree_edge_count >= target;
        r.vtx_lo = (a <= b) ? a : b;
        r.vtx_hi = (a <= b) ? b : a;
        r.weight = wt;
        if (fin)
            forest_clear();
        return r;
    endfunction

    function automatic stim_row_t e_row(logic [VERTEX_W-1:0] src, logic [VERTEX_W-1:0] dst,
                                        logic signed [WEIGHT_W-1:0] wt, logic fin);
        stim_row_t r;
        r.kind   = ROW_EDGE;
        r.src    = src;
        r.dst    = dst;
        r.wt     = wt;
        r.fin    = fin;
        r.vcount = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic stim_row_t t_row(logic [VERTEX_W-1:0] src, logic [VERTEX_W-1:0] dst,
                                        logic signed [WEIGHT_W-1:0] wt, logic fin,
                                        logic acc, logic [VERTEX_W-1:0] lo,
                                        logic [VERTEX_W-1:0] hi, logic done, logic bad);
        stim_row_t r;
        r = e_row(src, dst, wt, fin);
        r.typed         = 1'b1;
        r.want.accepted = acc;
        r.want.vtx_lo   = lo;
        r.want.vtx_hi   = hi;
        r.want.weight   = wt;
        r.want.done     = done;
        r.want.bad      = bad;
        return r;
    endfunction

    function automatic stim_row_t c_row(logic [VCOUNT_W-1:0] v);
        stim_row_t r;
        r = e_row('0, '0, '0, 1'b0);
        r.kind   = ROW_CFG;
        r.vcount = v;
        return r;
    endfunction

    task automatic send_edge(logic [VERTEX_W-1:0] src, logic [VERTEX_W-1:0] dst,
                             logic signed [WEIGHT_W-1:0] wt, logic fin,
                             bit typed, result_t want);
        result_t got;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        edge_from   <= src;
        edge_to     <= dst;
        edge_weight <= wt;
        last_edge   <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        got = mst_filter_predict(src, dst, wt, fin);
        pending_results.insert(pending_results.size(), typed ? want : got);
    endtask

    task automatic write_vcount(logic [VCOUNT_W-1:0] v);
        push <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        vertex_count_reg = v;
    endtask

    // well-formed graphs with random content, plus stray endpoints and unclosed graphs
    task automatic run_graphs(int quota);
        int                         sent;
        int                         gn;
        int                         ne;
        bit                         unclosed;
        logic [VERTEX_W-1:0]        a;
        logic [VERTEX_W-1:0]        b;
        logic signed [WEIGHT_W-1:0] w;
        sent = 0;
        while (sent < quota)
        begin
            gn = (vertex_count_reg > VCOUNT_W'(NV)) ? NV : int'(vertex_count_reg);
            if (gn == 0)
                gn = 4;
            ne       = $urandom_range(1, (gn < 14) ? 3 * gn : 40);
            unclosed = ($urandom_range(0, 9) == 0);
            w        = $signed($urandom()) >>> 1;
            for (int i = 0; i < ne; i++)
            begin
                a = ($urandom_range(0, 99) < 12) ? VERTEX_W'($urandom_range(0, 255))
                                                 : VERTEX_W'($urandom_range(0, gn - 1));
                b = ($urandom_range(0, 99) < 12) ? VERTEX_W'($urandom_range(0, 255))
                                                 : VERTEX_W'($urandom_range(0, gn - 1));
                w = w + $urandom_range(0, 1000);
                send_edge(a, b, w, (i == ne - 1) && !unclosed, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic note_field(string fname, logic [WEIGHT_W-1:0] want, logic [WEIGHT_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
        end
    endtask

    // receiver: check each popped beat, then pick next pop
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with none expected, got %0h/%0h/%0h",
                             $time, vertex_low, vertex_high, weight_out);
                end
                else
                begin
                    want = pending_results.pop_front();
                    note_field("accepted", want.accepted, accepted);
                    note_field("vertex_low", want.vtx_lo, vertex_low);
                    note_field("vertex_high", want.vtx_hi, vertex_high);
                    note_field("weight_out", want.weight, weight_out);
                    note_field("tree_complete", want.done, tree_complete);
                    note_field("bad_vertex", want.bad, bad_vertex);
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int vc_plan [12];
        rst_n       = 1'b0;
        push        = 1'b0;
        edge_from   = '0;
        edge_to     = '0;
        edge_weight = '0;
        last_edge   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        vc_plan     = '{256, 6, 1, 17, 0, 511, 12, 2, 257, 40, 9, 128};
        forest_clear();
        vertex_count_reg = VCOUNT_RESET;

        dir_tab = '{
            t_row(8'd0,   8'd255, 32'sh7FFFFFFF, 1'b0, 1'b1, 8'd0,   8'd255, 1'b0, 1'b0),
            t_row(8'd255, 8'd0,   32'sh80000000, 1'b0, 1'b0, 8'd0,   8'd255, 1'b0, 1'b0),
            t_row(8'd7,   8'd7,   32'sd0,        1'b0, 1'b0, 8'd7,   8'd7,   1'b0, 1'b0),
            e_row(8'd3,   8'd4,   32'sd100,      1'b0),
            e_row(8'd4,   8'd3,   32'sd100,      1'b0),
            e_row(8'd3,   8'd0,   32'sd200,      1'b0),
            e_row(8'd128, 8'd64,  -32'sd1,       1'b1),
            e_row(8'd255, 8'd0,   32'sd1,        1'b0),
            c_row(9'd1),
            t_row(8'd0,   8'd0,   32'sd5,        1'b0, 1'b0, 8'd0,   8'd0,   1'b1, 1'b0),
            t_row(8'd255, 8'd0,   32'sd6,        1'b0, 1'b0, 8'd0,   8'd255, 1'b1, 1'b1),
            c_row(9'd0),
            t_row(8'd0,   8'd0,   32'sd7,        1'b1, 1'b0, 8'd0,   8'd0,   1'b1, 1'b1),
            c_row(9'd511),
            t_row(8'd255, 8'd254, 32'sd9,        1'b0, 1'b1, 8'd254, 8'd255, 1'b0, 1'b0),
            e_row(8'd254, 8'd253, 32'sd10,       1'b1),
            c_row(9'd2),
            t_row(8'd1,   8'd0,   32'sd11,       1'b0, 1'b1, 8'd0,   8'd1,   1'b1, 1'b0),
            t_row(8'd0,   8'd1,   32'sd12,       1'b0, 1'b0, 8'd0,   8'd1,   1'b1, 1'b0),
            t_row(8'd2,   8'd1,   32'sd13,       1'b0, 1'b0, 8'd1,   8'd2,   1'b1, 1'b1),
            // widen the graph midway: forest and count carry over
            c_row(9'd4),
            e_row(8'd2,   8'd3,   32'sd14,       1'b0),
            e_row(8'd0,   8'd3,   32'sd15,       1'b0),
            e_row(8'd1,   8'd2,   32'sd16,       1'b0),
            e_row(8'd3,   8'd3,   32'sd17,       1'b1)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 48;
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_vcount(dir_tab[i].vcount);
            else
                send_edge(dir_tab[i].src, dir_tab[i].dst, dir_tab[i].wt, dir_tab[i].fin,
                          dir_tab[i].typed, dir_tab[i].want);
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 48 : 0;
            recv_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 37 : 0;
            for (int k = 0; k < 4; k++)
            begin
                write_vcount(VCOUNT_W'(vc_plan[mode * 4 + k]));
                run_graphs(27);
            end
        end

        push <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/kmf_pkg.sv
hw/rtl/kmf_queue.sv
hw/rtl/kmf_front.sv
hw/rtl/kmf_back.sv
hw/rtl/kruskal_mst_edge_filter_top.sv
sim/kruskal_mst_edge_filter_top_test.sv
